@@ sv/spk_pkg.sv @@
// ---------------------------------------------------------------------------
// spk_pkg: shared types and constants for the Speck64/128 block cipher
// Word width, rotation amounts, default round count and the round mode code
// used by the sequencer and the shared round unit.
// ---------------------------------------------------------------------------
package spk_pkg;

    localparam int WORD_W         = 32;
    localparam int NUM_ROUNDS_DEF = 27;
    localparam int NUM_KEY_WORDS  = 4;

    // Rotation amounts of the Speck64 round (all as left rotations)
    localparam int ROT_ALPHA_L     = 24;
    localparam int ROT_BETA_L      = 3;
    localparam int ROT_BETA_INV_L  = 29;
    localparam int ROT_ALPHA_INV_L = 8;

    typedef enum logic
    {
        MODE_ENC = 1'b0,
        MODE_DEC = 1'b1
    } round_mode_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EXPAND,
        ST_RUN
    } state_t;

    typedef enum logic [1:0]
    {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } reg_idx_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int s);
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v} << s;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

@@ sv/spk_round.sv @@
// ---------------------------------------------------------------------------
// spk_round: shared Speck64 round unit
// One encrypt or decrypt round on a word pair with a given round key. Used
// both for key expansion and for block processing.
// ---------------------------------------------------------------------------
module spk_round
    import spk_pkg::*;
(
    input  round_mode_t       mode,
    input  logic [WORD_W-1:0] hi_in,
    input  logic [WORD_W-1:0] lo_in,
    input  logic [WORD_W-1:0] round_key,
    output logic [WORD_W-1:0] hi_out,
    output logic [WORD_W-1:0] lo_out
);

    logic [WORD_W-1:0] enc_hi;
    logic [WORD_W-1:0] enc_lo;
    logic [WORD_W-1:0] dec_lo;
    logic [WORD_W-1:0] dec_diff;

    // Forward round: rotate high right by 8, add low, mix key
    assign enc_hi = (rotl(hi_in, ROT_ALPHA_L) + lo_in) ^ round_key;
    assign enc_lo = rotl(lo_in, ROT_BETA_L) ^ enc_hi;

    // Inverse round: undo the low mix, then subtract and rotate back
    assign dec_lo   = rotl(lo_in ^ hi_in, ROT_BETA_INV_L);
    assign dec_diff = (hi_in ^ round_key) - dec_lo;

    always_comb
    begin
        unique case (mode)
            MODE_ENC:
            begin
                hi_out = enc_hi;
                lo_out = enc_lo;
            end
            MODE_DEC:
            begin
                hi_out = rotl(dec_diff, ROT_ALPHA_INV_L);
                lo_out = dec_lo;
            end
            default:
            begin
                hi_out = enc_hi;
                lo_out = enc_lo;
            end
        endcase
    end

endmodule

@@ sv/spk_key_ram.sv @@
// ---------------------------------------------------------------------------
// spk_key_ram: round key store
// One write port filled by the key expansion, one read port with registered
// read data feeding the round unit.
// ---------------------------------------------------------------------------
module spk_key_ram
    import spk_pkg::*;
#(
    parameter int DEPTH = NUM_ROUNDS_DEF,
    parameter int AW    = $clog2(NUM_ROUNDS_DEF)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    // Store a round key
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ sv/speck64_128_block_cipher.sv @@
// An accepted block runs its rounds in ST_RUN and then shows on m_tvalid from the output register.
// One round per cycle on the shared round unit, except that a full output register holds the
// last round until the result transfer; the next block is transferred only in ST_IDLE, so a
// new block is not taken before the last one has left ST_RUN.
// Reset and every key write rerun the key expansion (a key load in ST_IDLE, then NUM_ROUNDS
// expansion rounds), during which s_tready stays low; the reset key is all zeros.
// ---------------------------------------------------------------------------
// speck64_128_block_cipher: Speck64/128 encrypt/decrypt engine
// APB key registers, a key expansion sequencer and an iterative block datapath
// sharing one round unit, with an output register towards the master side.
// ---------------------------------------------------------------------------
module speck64_128_block_cipher
    import spk_pkg::*;
#(
    parameter int NUM_ROUNDS = NUM_ROUNDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] block_low, [63:32] block_high
    input  logic        s_tuser,   // [0] command
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] result_low, [63:32] result_high
);

    localparam int CW = $clog2(NUM_ROUNDS);
    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_ROUNDS - 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    round_mode_t       mode_reg, mode_next;
    logic              pend_reg, pend_next;
    logic [WORD_W-1:0] hi_reg, hi_next;
    logic [WORD_W-1:0] lo_reg, lo_next;
    logic [WORD_W-1:0] s1_reg, s1_next;
    logic [WORD_W-1:0] s2_reg, s2_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_lo_reg, out_lo_next;
    logic [WORD_W-1:0] out_hi_reg, out_hi_next;
    logic [WORD_W-1:0] key_reg [NUM_KEY_WORDS];

    logic              cfg_wr;
    reg_idx_t          cfg_idx;
    logic              ram_we;
    logic [CW-1:0]     rd_addr;
    logic [WORD_W-1:0] round_key;
    round_mode_t       unit_mode;
    logic [WORD_W-1:0] unit_k;
    logic [WORD_W-1:0] unit_hi;
    logic [WORD_W-1:0] unit_lo;
    logic              last_round;

    // APB access decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign prdata  = key_reg[cfg_idx];

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEY_WORDS; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            key_reg[cfg_idx] <= pwdata;
        end
    end

    // Round key store
    spk_key_ram #(
        .DEPTH (NUM_ROUNDS),
        .AW    (CW)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg),
        .wr_data (lo_reg),
        .rd_addr (rd_addr),
        .rd_data (round_key)
    );

    // Shared round unit
    spk_round u_round (
        .mode      (unit_mode),
        .hi_in     (hi_reg),
        .lo_in     (lo_reg),
        .round_key (unit_k),
        .hi_out    (unit_hi),
        .lo_out    (unit_lo)
    );

    assign last_round = (cnt_reg == LAST_IDX);

    // Prefetch the key for the round that runs next cycle
    assign rd_addr = (mode_next == MODE_DEC) ? (LAST_IDX - cnt_next) : cnt_next;

    // Stream handshakes
    assign s_tready = (state_reg == ST_IDLE) && !pend_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_hi_reg, out_lo_reg};

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mode_next      = mode_reg;
        pend_next      = pend_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        out_valid_next = out_valid_reg;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;
        ram_we         = 1'b0;
        unit_mode      = MODE_ENC;
        unit_k         = round_key;

        // Drop the result once transferred
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (pend_reg)
                begin
                    // Load the key: low word is the first round key
                    lo_next    = key_reg[REG_KEY0];
                    hi_next    = key_reg[REG_KEY1];
                    s1_next    = key_reg[REG_KEY2];
                    s2_next    = key_reg[REG_KEY3];
                    mode_next  = MODE_ENC;
                    pend_next  = 1'b0;
                    state_next = ST_EXPAND;
                end
                else if (s_tvalid)
                begin
                    mode_next  = round_mode_t'(s_tuser);
                    lo_next    = s_tdata[31:0];
                    hi_next    = s_tdata[63:32];
                    state_next = ST_RUN;
                end
            end
            ST_EXPAND:
            begin
                // Store current key, advance schedule with rotating words
                ram_we  = 1'b1;
                unit_k  = WORD_W'(cnt_reg);
                lo_next = unit_lo;
                hi_next = s1_reg;
                s1_next = s2_reg;
                s2_next = unit_hi;
                if (last_round)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RUN:
            begin
                unit_mode = mode_reg;
                // Hold the final round while the output register is still full
                if (!(last_round && out_valid_reg && !m_tready))
                begin
                    hi_next = unit_hi;
                    lo_next = unit_lo;
                    if (last_round)
                    begin
                        out_lo_next    = unit_lo;
                        out_hi_next    = unit_hi;
                        out_valid_next = 1'b1;
                        cnt_next       = '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A key write always schedules a fresh expansion
        if (cfg_wr)
        begin
            pend_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mode_reg      <= MODE_ENC;
            pend_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mode_reg      <= mode_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        out_lo_reg <= out_lo_next;
        out_hi_reg <= out_hi_next;
    end

    // A block is never taken while an expansion is owed
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_reg)
        else $error("block accepted with key expansion pending");

    // An accepted block starts at round zero
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_RUN && cnt_reg == '0))
        else $error("accepted block did not start at round zero");

    // A key write always leads to a new expansion
    a_write_marks_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> pend_reg)
        else $error("key write did not schedule expansion");

    // Round counter stays within the key store
    a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXPAND || state_reg == ST_RUN) |-> (cnt_reg <= LAST_IDX))
        else $error("round counter out of range");

endmodule

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb: self-checking testbench for the Speck64/128 block cipher
// Loads keys over the APB port (with read-back), streams encrypt and decrypt
// blocks with random gaps on both sides, and checks every result against a
// word-level model of the round-key schedule and the 27-round cipher.
// ---------------------------------------------------------------------------
module tb;
    import spk_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 150;

    // Holds the key, the expanded round keys and the blocks awaiting their result
    class cipher_scoreboard;
        logic [31:0] key_reg [NUM_KEY_WORDS];
        logic [31:0] sched_key [NUM_ROUNDS_DEF];
        logic [63:0] expected_q [$];
        int errors;

        function new();
            foreach (key_reg[k])
                key_reg[k] = '0;
            errors = 0;
            expand_schedule();
        endfunction

        static function logic [31:0] rol(logic [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        // Rebuild the round keys from the current four key words
        function void expand_schedule();
            logic [31:0] a;
            logic [31:0] h;
            logic [31:0] w [3];
            a = key_reg[0];
            for (int k = 0; k < 3; k++)
                w[k] = key_reg[k + 1];
            for (int i = 0; i < NUM_ROUNDS_DEF; i++)
            begin
                sched_key[i] = a;
                h = (rol(w[i % 3], 24) + a) ^ 32'(i);
                a = rol(a, 3) ^ h;
                w[i % 3] = h;
            end
        endfunction

        function void note_key(reg_idx_t idx, logic [31:0] value);
            key_reg[idx] = value;
            expand_schedule();
        endfunction

        // Work out the result of one accepted block and queue it
        function void note_block(round_mode_t mode, logic [31:0] lo, logic [31:0] hi);
            logic [31:0] l;
            logic [31:0] h;
            l = lo;
            h = hi;
            if (mode == MODE_ENC)
            begin
                for (int i = 0; i < NUM_ROUNDS_DEF; i++)
                begin
                    h = (rol(h, 24) + l) ^ sched_key[i];
                    l = rol(l, 3) ^ h;
                end
            end
            else
            begin
                for (int i = NUM_ROUNDS_DEF - 1; i >= 0; i--)
                begin
                    l = rol(l ^ h, 29);
                    h = rol((h ^ sched_key[i]) - l, 8);
                end
            end
            expected_q.push_back({h, l});
        endfunction

        function void check_result(logic [31:0] lo, logic [31:0] hi);
            logic [63:0] exp_word;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no block waiting: low %h high %h", $time, lo, hi);
                errors++;
                return;
            end
            exp_word = expected_q.pop_front();
            if (lo !== exp_word[31:0])
            begin
                $display("%0t: result_low expected %h actual %h", $time, exp_word[31:0], lo);
                errors++;
            end
            if (hi !== exp_word[63:32])
            begin
                $display("%0t: result_high expected %h actual %h", $time, exp_word[63:32], hi);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // [31:0] block_low, [63:32] block_high
    logic        s_tuser;    // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;    // [31:0] result_low, [63:32] result_high

    int               idle_pct = 35;
    int               cycle_count = 0;
    cipher_scoreboard sb;

    speck64_128_block_cipher DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the master side at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= idle_pct);

    // Note each block transfer and check each result transfer
    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_block(round_mode_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], m_tdata[63:32]);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // One APB transfer: setup, access, then psel and penable low again before returning
    task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] value,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write one key word once the block is idle, then read it back
    task automatic write_key(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] rdata;
        while (!s_tready)
            @(posedge clk);
        apb_access(1'b1, idx, value, rdata);
        sb.note_key(idx, value);
        apb_access(1'b0, idx, '0, rdata);
        if (rdata !== value)
        begin
            $display("%0t: key word %0d read expected %h actual %h", $time, idx, value, rdata);
            sb.errors++;
        end
    endtask

    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        write_key(REG_KEY0, k0);
        write_key(REG_KEY1, k1);
        write_key(REG_KEY2, k2);
        write_key(REG_KEY3, k3);
    endtask

    // Offer one block after a random gap and hold it until the transfer
    task automatic send_block(input round_mode_t mode, input logic [31:0] lo,
                              input logic [31:0] hi);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int nw;
        sb = new();
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset key, extreme blocks
        send_block(MODE_ENC, '0, '0);
        send_block(MODE_DEC, '0, '0);
        send_block(MODE_ENC, '1, '1);
        send_block(MODE_DEC, '1, '1);
        drain();

        // Published test key, its plaintext and ciphertext, bit patterns
        load_key(32'h03020100, 32'h0b0a0908, 32'h13121110, 32'h1b1a1918);
        send_block(MODE_ENC, 32'h7475432d, 32'h3b726574);
        send_block(MODE_DEC, 32'h454e028b, 32'h8c6fa548);
        send_block(MODE_ENC, 32'haaaaaaaa, 32'h55555555);
        send_block(MODE_DEC, 32'h55555555, 32'haaaaaaaa);
        send_block(MODE_ENC, '0, '1);
        send_block(MODE_DEC, '1, '0);
        drain();

        // Partial key update: change a single word at a time
        write_key(REG_KEY2, '1);
        send_block(MODE_ENC, 32'h7475432d, 32'h3b726574);
        send_block(MODE_DEC, 32'h454e028b, 32'h8c6fa548);
        drain();
        write_key(REG_KEY0, '0);
        send_block(MODE_ENC, 32'h01234567, 32'h89abcdef);
        send_block(MODE_DEC, 32'h01234567, 32'h89abcdef);
        drain();

        // All-ones key
        load_key('1, '1, '1, '1);
        send_block(MODE_ENC, '0, '0);
        send_block(MODE_DEC, '1, '1);
        drain();

        // Random phases, each under a fresh partial or full key update
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            nw = $urandom_range(1, NUM_KEY_WORDS);
            for (int k = 0; k < nw; k++)
                write_key(reg_idx_t'($urandom_range(NUM_KEY_WORDS - 1)), rand_word());
            idle_pct = (phase == 3) ? 0 : 35;
            repeat (PHASE_ITEMS)
                send_block(round_mode_t'($urandom_range(1)), rand_word(), rand_word());
            drain();
        end
        idle_pct = 35;

        repeat (NUM_ROUNDS_DEF + 8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
